[hdl/c2bm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2bm_pkg
// Shared widths, codes, register map and control types of the 2-D
// convolution block with boundary folding.
// ----------------------------------------------------------------------------
package c2bm_pkg;

  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int MAX_KERNEL_DEF = 5;

  localparam int POS_W  = 6;
  localparam int VAL_W  = 16;
  localparam int DIM_W  = 7;
  localparam int KDIM_W = 3;
  localparam int CRD_W  = 10;
  localparam int PROD_W = 32;
  localparam int RES_W  = 37;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 56;

  localparam int CFG_AW    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROWS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_COLS   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOUNDARY_MODE = 3'd4;

  localparam logic [DIM_W-1:0]  IMAGE_ROWS_RST  = 7'd64;
  localparam logic [DIM_W-1:0]  IMAGE_COLS_RST  = 7'd64;
  localparam logic [KDIM_W-1:0] KERNEL_ROWS_RST = 3'd5;
  localparam logic [KDIM_W-1:0] KERNEL_COLS_RST = 3'd5;

  typedef enum logic [1:0] {
    OP_LOAD_COEF  = 2'd0,
    OP_LOAD_PIXEL = 2'd1,
    OP_COMPUTE    = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BM_MIRROR    = 2'd0,
    BM_CIRCULAR  = 2'd1,
    BM_REPLICATE = 2'd2,
    BM_INVALID   = 2'd3
  } bmode_t;

  typedef struct packed {
    logic [DIM_W-1:0]  nr;
    logic [DIM_W-1:0]  nc;
    logic [KDIM_W-1:0] kr;
    logic [KDIM_W-1:0] kc;
    bmode_t            mode;
  } cfg_t;

  typedef struct packed {
    logic             tap;
    logic             first;
    logic             last;
    logic             bad;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } seq_ctl_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[hdl/c2bm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2bm_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module c2bm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [c2bm_pkg::addr_w(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [c2bm_pkg::addr_w(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]                     rdata
);
  import c2bm_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/c2bm_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2bm_cfg
// APB register file for image size, kernel size and boundary mode, with the
// sizes saturated to their legal ranges.
// ----------------------------------------------------------------------------
module c2bm_cfg #(
  parameter int MAX_ROWS   = c2bm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = c2bm_pkg::MAX_COLS_DEF,
  parameter int MAX_KERNEL = c2bm_pkg::MAX_KERNEL_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [c2bm_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output c2bm_pkg::cfg_t                cfg
);
  import c2bm_pkg::*;

  logic [DIM_W-1:0]     image_rows;
  logic [DIM_W-1:0]     image_cols;
  logic [KDIM_W-1:0]    kernel_rows;
  logic [KDIM_W-1:0]    kernel_cols;
  logic [1:0]           boundary_mode;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_AW-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows    <= IMAGE_ROWS_RST;
      image_cols    <= IMAGE_COLS_RST;
      kernel_rows   <= KERNEL_ROWS_RST;
      kernel_cols   <= KERNEL_COLS_RST;
      boundary_mode <= BM_MIRROR;
    end else if (wr) begin
      unique case (idx)
        REG_IMAGE_ROWS:    image_rows    <= pwdata[DIM_W-1:0];
        REG_IMAGE_COLS:    image_cols    <= pwdata[DIM_W-1:0];
        REG_KERNEL_ROWS:   kernel_rows   <= pwdata[KDIM_W-1:0];
        REG_KERNEL_COLS:   kernel_cols   <= pwdata[KDIM_W-1:0];
        REG_BOUNDARY_MODE: boundary_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_ROWS:    prdata = 32'(image_rows);
      REG_IMAGE_COLS:    prdata = 32'(image_cols);
      REG_KERNEL_ROWS:   prdata = 32'(kernel_rows);
      REG_KERNEL_COLS:   prdata = 32'(kernel_cols);
      REG_BOUNDARY_MODE: prdata = 32'(boundary_mode);
      default:           prdata = '0;
    endcase
  end

  // saturate sizes
  always_comb begin
    if (image_rows < DIM_W'(2)) begin
      cfg.nr = DIM_W'(2);
    end else if (32'(image_rows) > MAX_ROWS) begin
      cfg.nr = DIM_W'(MAX_ROWS);
    end else begin
      cfg.nr = image_rows;
    end
    if (image_cols < DIM_W'(2)) begin
      cfg.nc = DIM_W'(2);
    end else if (32'(image_cols) > MAX_COLS) begin
      cfg.nc = DIM_W'(MAX_COLS);
    end else begin
      cfg.nc = image_cols;
    end
    if (kernel_rows < KDIM_W'(1)) begin
      cfg.kr = KDIM_W'(1);
    end else if (32'(kernel_rows) > MAX_KERNEL) begin
      cfg.kr = KDIM_W'(MAX_KERNEL);
    end else begin
      cfg.kr = kernel_rows;
    end
    if (kernel_cols < KDIM_W'(1)) begin
      cfg.kc = KDIM_W'(1);
    end else if (32'(kernel_cols) > MAX_KERNEL) begin
      cfg.kc = KDIM_W'(MAX_KERNEL);
    end else begin
      cfg.kc = kernel_cols;
    end
    cfg.mode = bmode_t'(boundary_mode);
  end

endmodule

[hdl/c2bm_fold.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2bm_fold
// Folds one tap coordinate back into the image by the boundary mode and
// flags an outside tap under the invalid mode.
// ----------------------------------------------------------------------------
module c2bm_fold #(
  parameter int MAX_KERNEL = c2bm_pkg::MAX_KERNEL_DEF
) (
  input  logic signed [c2bm_pkg::CRD_W-1:0] p,
  input  logic [c2bm_pkg::DIM_W-1:0]        n,
  input  c2bm_pkg::bmode_t                  mode,
  output logic [c2bm_pkg::DIM_W-1:0]        idx,
  output logic                              bad
);
  import c2bm_pkg::*;

  // a tap lies at most half a kernel outside, so a few wrap steps suffice
  localparam int WRAP_STEPS = (MAX_KERNEL / 2 + 1) / 2;

  logic signed [CRD_W-1:0] ns;
  logic signed [CRD_W-1:0] hi;
  logic signed [CRD_W-1:0] mir;
  logic signed [CRD_W-1:0] wrp;
  logic signed [CRD_W-1:0] sel;
  logic                    in_img;

  assign ns     = {{(CRD_W-DIM_W){1'b0}}, n};
  assign hi     = ns - CRD_W'(1);
  assign in_img = (p >= 0) && (p < ns);

  always_comb begin
    mir = (p < 0) ? -p : (ns + ns - p - CRD_W'(2));
    if (mir < 0) begin
      mir = '0;
    end else if (mir > hi) begin
      mir = hi;
    end
    wrp = p;
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (wrp < 0) begin
        wrp = wrp + ns;
      end else if (wrp >= ns) begin
        wrp = wrp - ns;
      end
    end
    bad = 1'b0;
    if (in_img) begin
      sel = p;
    end else begin
      unique case (mode)
        BM_MIRROR:    sel = mir;
        BM_CIRCULAR:  sel = wrp;
        BM_REPLICATE: sel = (p < 0) ? '0 : hi;
        BM_INVALID: begin
          sel = '0;
          bad = 1'b1;
        end
        default:      sel = '0;
      endcase
    end
    idx = sel[DIM_W-1:0];
  end

endmodule

[hdl/c2bm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2bm_seq
// Input sequencer: writes loads into the two memories and walks the kernel
// taps of a compute, issuing one image and one coefficient read per cycle.
// ----------------------------------------------------------------------------
module c2bm_seq #(
  parameter int MAX_ROWS   = c2bm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = c2bm_pkg::MAX_COLS_DEF,
  parameter int MAX_KERNEL = c2bm_pkg::MAX_KERNEL_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  c2bm_pkg::cfg_t                                         cfg,
  input  logic                                                   s_tvalid,
  output logic                                                   s_tready,
  input  logic [c2bm_pkg::S_TDATA_W-1:0]                         s_tdata,
  input  logic [c2bm_pkg::S_TUSER_W-1:0]                         s_tuser,
  output logic                                                   img_we,
  output logic [c2bm_pkg::addr_w(MAX_ROWS*MAX_COLS)-1:0]         img_waddr,
  output logic [c2bm_pkg::addr_w(MAX_ROWS*MAX_COLS)-1:0]         img_raddr,
  output logic                                                   coef_we,
  output logic [c2bm_pkg::addr_w(MAX_KERNEL*MAX_KERNEL)-1:0]     coef_waddr,
  output logic [c2bm_pkg::addr_w(MAX_KERNEL*MAX_KERNEL)-1:0]     coef_raddr,
  output logic [c2bm_pkg::VAL_W-1:0]                             wdata,
  output c2bm_pkg::seq_ctl_t                                     ctl,
  input  logic                                                   done
);
  import c2bm_pkg::*;

  localparam int IMG_AW = addr_w(MAX_ROWS * MAX_COLS);
  localparam int KAW    = addr_w(MAX_KERNEL * MAX_KERNEL);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [POS_W-1:0]   row;
  logic [POS_W-1:0]   col;
  logic [KDIM_W-1:0]  ii;
  logic [KDIM_W-1:0]  jj;
  logic               bad;
  logic [KDIM_W-1:0]  ii_next;
  logic [KDIM_W-1:0]  jj_next;
  logic               bad_next;

  op_t                op;
  logic [POS_W-1:0]   in_row;
  logic [POS_W-1:0]   in_col;
  logic               accept;
  logic               start;
  logic               row_end;
  logic               last;

  logic signed [CRD_W-1:0] pr;
  logic signed [CRD_W-1:0] pc;
  logic [DIM_W-1:0]        r_idx;
  logic [DIM_W-1:0]        c_idx;
  logic                    r_bad;
  logic                    c_bad;

  assign op     = op_t'(s_tuser);
  assign in_row = s_tdata[POS_W-1:0];
  assign in_col = s_tdata[2*POS_W-1:POS_W];
  assign wdata  = s_tdata[2*POS_W+VAL_W-1:2*POS_W];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign coef_we    = accept && (op == OP_LOAD_COEF) &&
                      (32'(in_row) < MAX_KERNEL) && (32'(in_col) < MAX_KERNEL);
  assign coef_waddr = KAW'(in_row * MAX_KERNEL) + KAW'(in_col);
  assign img_we     = accept && (op == OP_LOAD_PIXEL) &&
                      (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
  assign img_waddr  = IMG_AW'(in_row * MAX_COLS) + IMG_AW'(in_col);
  assign start      = accept && (op == OP_COMPUTE) &&
                      ({1'b0, in_row} < cfg.nr) && ({1'b0, in_col} < cfg.nc);

  // tap position relative to the kernel center
  assign pr = CRD_W'(row) + CRD_W'(ii) - CRD_W'(cfg.kr >> 1);
  assign pc = CRD_W'(col) + CRD_W'(jj) - CRD_W'(cfg.kc >> 1);

  c2bm_fold #(.MAX_KERNEL(MAX_KERNEL)) u_fold_row (
    .p    (pr),
    .n    (cfg.nr),
    .mode (cfg.mode),
    .idx  (r_idx),
    .bad  (r_bad)
  );

  c2bm_fold #(.MAX_KERNEL(MAX_KERNEL)) u_fold_col (
    .p    (pc),
    .n    (cfg.nc),
    .mode (cfg.mode),
    .idx  (c_idx),
    .bad  (c_bad)
  );

  assign img_raddr  = IMG_AW'(r_idx * MAX_COLS) + IMG_AW'(c_idx);
  assign coef_raddr = KAW'(ii * MAX_KERNEL) + KAW'(jj);

  assign row_end = (jj == cfg.kc - KDIM_W'(1));
  assign last    = row_end && (ii == cfg.kr - KDIM_W'(1));

  always_comb begin
    state_next = state;
    ii_next    = ii;
    jj_next    = jj;
    bad_next   = bad;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RUN;
          ii_next    = '0;
          jj_next    = '0;
          bad_next   = 1'b0;
        end
      end
      S_RUN: begin
        bad_next = bad || r_bad || c_bad;
        if (row_end) begin
          jj_next = '0;
          ii_next = ii + KDIM_W'(1);
        end else begin
          jj_next = jj + KDIM_W'(1);
        end
        if (last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    ii  <= ii_next;
    jj  <= jj_next;
    bad <= bad_next;
    if (start) begin
      row <= in_row;
      col <= in_col;
    end
  end

  assign ctl.tap   = (state == S_RUN);
  assign ctl.first = (ii == '0) && (jj == '0);
  assign ctl.last  = last;
  assign ctl.bad   = bad;
  assign ctl.row   = row;
  assign ctl.col   = col;

endmodule

[hdl/c2bm_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2bm_mac
// Multiply-accumulate behind the memory reads, saturation and the output
// register of the result stream.
// ----------------------------------------------------------------------------
module c2bm_mac #(
  parameter int MAX_KERNEL = c2bm_pkg::MAX_KERNEL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  c2bm_pkg::seq_ctl_t                ctl,
  input  logic [c2bm_pkg::VAL_W-1:0]        img_q,
  input  logic [c2bm_pkg::VAL_W-1:0]        coef_q,
  output logic                              done,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [c2bm_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tuser
);
  import c2bm_pkg::*;

  localparam int GROW_W = PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int ACC_W  = (GROW_W > RES_W + 1) ? GROW_W : RES_W + 1;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}};

  logic                     tap_d1;
  logic                     first_d1;
  logic                     last_d1;
  logic                     tap_d2;
  logic                     first_d2;
  logic                     last_d2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     fin;
  logic signed [ACC_W-1:0]  sat;
  logic [RES_W-1:0]         res;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_d1 <= 1'b0;
      tap_d2 <= 1'b0;
    end else begin
      tap_d1 <= ctl.tap;
      tap_d2 <= tap_d1;
    end
  end

  always_ff @(posedge clk) begin
    first_d1 <= ctl.first;
    last_d1  <= ctl.last;
    first_d2 <= first_d1;
    last_d2  <= last_d1;
    prod     <= $signed(img_q) * $signed(coef_q);
    if (tap_d2) begin
      acc <= first_d2 ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  always_comb begin
    if (acc > SAT_HI) begin
      sat = SAT_HI;
    end else if (acc < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = acc;
    end
    res = ctl.bad ? '0 : sat[RES_W-1:0];
  end

  assign done = fin && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (tap_d2 && last_d2) begin
        fin <= 1'b1;
      end else if (done) begin
        fin <= 1'b0;
      end
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= M_TDATA_W'({res, ctl.col, ctl.row});
      m_tuser <= ctl.bad;
    end
  end

endmodule

[hdl/conv2d_boundary_modes.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_boundary_modes
// 2-D convolution of a stored image with a stored kernel, one output
// position per compute transfer, with mirror, circular or replicate folding or an invalid-tap flag.
// ----------------------------------------------------------------------------
// Load transfers write one coefficient or one pixel each. A compute transfer
// walks the kernel taps through one image memory read port and one
// multiply-accumulate unit, one tap a cycle; the next transfer is taken only
// once the taps are through and the result has entered the output register,
// which is held back while an earlier result is still unread there; the result then
// waits in the output register while loads go on. There is no clearing pass:
// a pixel or coefficient must be loaded before a compute reads it.
module conv2d_boundary_modes #(
  parameter int MAX_ROWS   = c2bm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = c2bm_pkg::MAX_COLS_DEF,
  parameter int MAX_KERNEL = c2bm_pkg::MAX_KERNEL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [c2bm_pkg::CFG_AW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // row[5:0], col[11:6], value[27:12], zero fill
  input  logic [c2bm_pkg::S_TDATA_W-1:0]    s_tdata,
  // op[1:0]
  input  logic [c2bm_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_row[5:0], out_col[11:6], result_value[48:12], zero fill
  output logic [c2bm_pkg::M_TDATA_W-1:0]    m_tdata,
  // status[0]
  output logic                              m_tuser
);
  import c2bm_pkg::*;

  localparam int IMG_AW = addr_w(MAX_ROWS * MAX_COLS);
  localparam int KAW    = addr_w(MAX_KERNEL * MAX_KERNEL);

  cfg_t              cfg;
  seq_ctl_t          ctl;
  logic              done;
  logic              img_we;
  logic [IMG_AW-1:0] img_waddr;
  logic [IMG_AW-1:0] img_raddr;
  logic              coef_we;
  logic [KAW-1:0]    coef_waddr;
  logic [KAW-1:0]    coef_raddr;
  logic [VAL_W-1:0]  wdata;
  logic [VAL_W-1:0]  img_q;
  logic [VAL_W-1:0]  coef_q;

  c2bm_cfg #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  c2bm_seq #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .img_we     (img_we),
    .img_waddr  (img_waddr),
    .img_raddr  (img_raddr),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_raddr (coef_raddr),
    .wdata      (wdata),
    .ctl        (ctl),
    .done       (done)
  );

  c2bm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ROWS * MAX_COLS)
  ) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (wdata),
    .raddr (img_raddr),
    .rdata (img_q)
  );

  c2bm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_KERNEL * MAX_KERNEL)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (wdata),
    .raddr (coef_raddr),
    .rdata (coef_q)
  );

  c2bm_mac #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .img_q    (img_q),
    .coef_q   (coef_q),
    .done     (done),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
